// File: hw/rtl/gas_pkg.sv
package gas_pkg;

  localparam int DATA_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIR_BITS  = FRAC_BITS + 2;
  localparam int QUO_BITS  = DATA_BITS + FRAC_BITS;
  localparam int MUL_LAT   = 2;
  localparam int DIV_LAT   = QUO_BITS + 2;

  typedef logic signed [DATA_BITS-1:0] fx_t;
  typedef logic signed [DIR_BITS-1:0]  dir_t;

  typedef struct packed {
    fx_t  v;
    logic sat;
  } fxs_t;

  typedef struct packed {
    logic vld;
    logic hz;
    logic flg;
  } ctl_t;

  localparam fx_t FX_MAX  = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam fx_t FX_MIN  = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam fx_t FX_ONE  = fx_t'(64'd1 << FRAC_BITS);
  localparam fx_t FX_HALF = fx_t'(64'd1 << (FRAC_BITS - 1));
  localparam fx_t FX_TWO  = fx_t'(64'd2 << FRAC_BITS);

  function automatic fxs_t sat_add(fx_t a, fx_t b);
    logic [DATA_BITS:0] s;
    fxs_t r;
    s = {a[DATA_BITS-1], a} + {b[DATA_BITS-1], b};
    r.sat = s[DATA_BITS] != s[DATA_BITS-1];
    r.v = r.sat ? (s[DATA_BITS] ? FX_MIN : FX_MAX) : fx_t'(s[DATA_BITS-1:0]);
    return r;
  endfunction

  function automatic fxs_t sat_sub(fx_t a, fx_t b);
    logic [DATA_BITS:0] s;
    fxs_t r;
    s = {a[DATA_BITS-1], a} - {b[DATA_BITS-1], b};
    r.sat = s[DATA_BITS] != s[DATA_BITS-1];
    r.v = r.sat ? (s[DATA_BITS] ? FX_MIN : FX_MAX) : fx_t'(s[DATA_BITS-1:0]);
    return r;
  endfunction

  function automatic fx_t dir_ext(dir_t d);
    return {{(DATA_BITS-DIR_BITS){d[DIR_BITS-1]}}, d};
  endfunction

endpackage

// File: hw/rtl/gas_mul.sv
module gas_mul (
  input  logic          clk,
  input  logic          en,
  input  gas_pkg::fx_t  a,
  input  gas_pkg::fx_t  b,
  output gas_pkg::fx_t  p,
  output logic          sat
);

  localparam int DW = gas_pkg::DATA_BITS;
  localparam int FW = gas_pkg::FRAC_BITS;

  logic [DW-1:0]      ua;
  logic [DW-1:0]      ub;
  logic [2*DW-1:0]    prod_r;
  logic               neg_r;
  logic [2*DW-1:0]    rnd;
  logic [2*DW-FW-1:0] mag;
  logic [DW-1:0]      lim;
  logic               over;
  gas_pkg::fx_t       p_nxt;
  gas_pkg::fx_t       p_r;
  logic               sat_r;

  assign ua = a[DW-1] ? (~a + 1'b1) : a;
  assign ub = b[DW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ua * ub;
      neg_r  <= a[DW-1] ^ b[DW-1];
    end
  end

  always_comb begin
    rnd  = prod_r + {{(2*DW-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}};
    mag  = rnd[2*DW-1:FW];
    lim  = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    over = mag > {{(DW-FW){1'b0}}, lim};
    if (over) begin
      p_nxt = neg_r ? gas_pkg::FX_MIN : gas_pkg::FX_MAX;
    end else if (neg_r) begin
      p_nxt = gas_pkg::fx_t'(~mag[DW-1:0] + 1'b1);
    end else begin
      p_nxt = gas_pkg::fx_t'(mag[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      sat_r <= over;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

// File: hw/rtl/gas_div.sv
module gas_div (
  input  logic          clk,
  input  logic          en,
  input  gas_pkg::fx_t  num,
  input  gas_pkg::fx_t  den,
  output gas_pkg::fx_t  q,
  output logic          sat
);

  localparam int DW = gas_pkg::DATA_BITS;
  localparam int FW = gas_pkg::FRAC_BITS;
  localparam int QW = gas_pkg::QUO_BITS;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nq;
    logic [DW-1:0] d;
    logic          neg;
    logic          zero;
    logic          nneg;
  } dst_t;

  function automatic dst_t div_step(dst_t s);
    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        ge;
    dst_t        o;
    rs    = {s.rem, s.nq[QW-1]};
    diff  = rs - {1'b0, s.d};
    ge    = rs >= {1'b0, s.d};
    o     = s;
    o.rem = ge ? diff[DW-1:0] : rs[DW-1:0];
    o.nq  = {s.nq[QW-2:0], ge};
    return o;
  endfunction

  dst_t          st_r [0:QW];
  dst_t          st_nxt [1:QW];
  logic [DW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [DW-1:0] lim;
  logic          over;
  gas_pkg::fx_t  q_nxt;
  logic          sat_nxt;
  gas_pkg::fx_t  q_r;
  logic          sat_r;

  assign nmag = num[DW-1] ? (~num + 1'b1) : num;
  assign dmag = den[DW-1] ? (~den + 1'b1) : den;

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem  <= '0;
      st_r[0].nq   <= {nmag, {FW{1'b0}}};
      st_r[0].d    <= dmag;
      st_r[0].neg  <= num[DW-1] ^ den[DW-1];
      st_r[0].zero <= dmag == '0;
      st_r[0].nneg <= num[DW-1];
      for (int k = 1; k <= QW; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    lim  = st_r[QW].neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    over = st_r[QW].nq > {{FW{1'b0}}, lim};
    if (st_r[QW].zero) begin
      q_nxt   = st_r[QW].nneg ? gas_pkg::FX_MIN : gas_pkg::FX_MAX;
      sat_nxt = 1'b1;
    end else if (over) begin
      q_nxt   = st_r[QW].neg ? gas_pkg::FX_MIN : gas_pkg::FX_MAX;
      sat_nxt = 1'b1;
    end else if (st_r[QW].neg) begin
      q_nxt   = gas_pkg::fx_t'(~st_r[QW].nq[DW-1:0] + 1'b1);
      sat_nxt = 1'b0;
    end else begin
      q_nxt   = gas_pkg::fx_t'(st_r[QW].nq[DW-1:0]);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign q   = q_r;
  assign sat = sat_r;

endmodule

// File: hw/rtl/geodesic_accel_schwarzschild.sv
// Schwarzschild geodesic acceleration: one state per transfer in, one velocity change per
// transfer out, sustained at one item per clock while input is not stalled. Pipeline depth
// from input transfer to a valid output is set by the r^-3 path: two multipliers, then the
// restoring divider that resolves one of its 48 quotient bits per stage, then a product
// level and the final step-size multiply. A result held at the output does not stop input:
// a one-entry skid stage absorbs the next result, and input stalls only while it is full.
// Fault is set for radius at or below the horizon (all outputs zero) or on any saturation.
module geodesic_accel_schwarzschild (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gas_pkg::fx_t        in_pos_radius,
  input  gas_pkg::dir_t       in_dir_x,
  input  gas_pkg::dir_t       in_dir_y,
  input  gas_pkg::dir_t       in_dir_z,
  input  gas_pkg::fx_t        in_vel_time,
  input  gas_pkg::fx_t        in_vel_radius,
  input  gas_pkg::fx_t        in_vel_x,
  input  gas_pkg::fx_t        in_vel_y,
  input  gas_pkg::fx_t        in_vel_z,
  input  gas_pkg::fx_t        in_step_size,
  output logic                out_valid,
  input  logic                out_ready,
  output gas_pkg::fx_t        out_dv_time,
  output gas_pkg::fx_t        out_dv_radius,
  output gas_pkg::fx_t        out_dv_x,
  output gas_pkg::fx_t        out_dv_y,
  output gas_pkg::fx_t        out_dv_z,
  output logic                out_fault
);

  localparam int DW    = gas_pkg::DATA_BITS;
  localparam int T_RR  = gas_pkg::MUL_LAT;
  localparam int T_R3  = 2 * gas_pkg::MUL_LAT;
  localparam int T_INV = gas_pkg::DIV_LAT;
  localparam int T_Z   = gas_pkg::MUL_LAT + gas_pkg::DIV_LAT;
  localparam int TA    = T_R3 + gas_pkg::DIV_LAT;
  localparam int T_P   = TA + gas_pkg::MUL_LAT;
  localparam int T_ACC = T_P + 1;
  localparam int T_OUT = T_ACC + gas_pkg::MUL_LAT;

  typedef struct packed {
    gas_pkg::fx_t  c;
    gas_pkg::dir_t dx;
    gas_pkg::dir_t dy;
    gas_pkg::dir_t dz;
  } a_t;

  typedef struct packed {
    gas_pkg::fx_t v01;
    gas_pkg::fx_t v11;
    gas_pkg::fx_t v00;
    gas_pkg::fx_t v21;
    gas_pkg::fx_t v31;
    gas_pkg::fx_t v41;
    gas_pkg::fx_t s;
  } b_t;

  typedef struct packed {
    gas_pkg::fx_t z;
    gas_pkg::fx_t z2;
  } z_t;

  typedef struct packed {
    gas_pkg::fx_t dt;
    gas_pkg::fx_t dr;
    gas_pkg::fx_t dx;
    gas_pkg::fx_t dy;
    gas_pkg::fx_t dz;
    logic         fault;
  } res_t;

  logic           en;
  gas_pkg::ctl_t  ctl_r [0:T_OUT];
  gas_pkg::ctl_t  ctl_in [1:T_OUT];
  a_t             a_r [0:TA];
  gas_pkg::fx_t   r_r [0:T_RR];
  gas_pkg::fx_t   h_r [0:T_ACC];
  gas_pkg::fx_t   vt_r, vr_r, vx_r, vy_r, vz_r;
  b_t             b_r [T_RR+1:TA];
  gas_pkg::fx_t   inv_r [T_INV+1:TA];
  z_t             z_r [T_Z+1:TA];
  gas_pkg::fx_t   acc_r [0:4];

  gas_pkg::fx_t   rr_p, rc_p, r3_p, v01_p, v11_p, v00_p, vxx_p, vyy_p, vzz_p;
  gas_pkg::fx_t   v21_p, v31_p, v41_p;
  logic           rr_s, rc_s, r3_s, v01_s, v11_s, v00_s, vxx_s, vyy_s, vzz_s;
  logic           v21_s, v31_s, v41_s;
  gas_pkg::fx_t   inv_q, z_q, gtt_q;
  logic           inv_s, z_s, gtt_s;
  gas_pkg::fxs_t  s1, s2, z2;
  b_t             b_src;
  logic           f_rr, f_p, f_out;

  gas_pkg::fx_t   gth;
  gas_pkg::fx_t   p0_p, p1a_p, p1b_p, p1c_p, p2x_p, p2y_p, p2z_p, pdx_p, pdy_p, pdz_p;
  logic           p0_s, p1a_s, p1b_s, p1c_s, p2x_s, p2y_s, p2z_s, pdx_s, pdy_s, pdz_s;
  gas_pkg::fxs_t  a0, t1, a1, tx, ty, tz, ax, ay, az;

  gas_pkg::fx_t   f0_p, f1_p, f2_p, f3_p, f4_p;
  logic           f0_s, f1_s, f2_s, f3_s, f4_s;

  res_t           pd;
  logic           take;
  res_t           out_d_r;
  res_t           skid_d_r;
  logic           out_valid_r;
  logic           skid_v_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  gas_mul u_rr  (.clk, .en, .a(r_r[0]), .b(r_r[0]),   .p(rr_p),  .sat(rr_s));
  gas_mul u_rc  (.clk, .en, .a(r_r[0]), .b(a_r[0].c), .p(rc_p),  .sat(rc_s));
  gas_mul u_v01 (.clk, .en, .a(vt_r),   .b(vr_r),     .p(v01_p), .sat(v01_s));
  gas_mul u_v11 (.clk, .en, .a(vr_r),   .b(vr_r),     .p(v11_p), .sat(v11_s));
  gas_mul u_v00 (.clk, .en, .a(vt_r),   .b(vt_r),     .p(v00_p), .sat(v00_s));
  gas_mul u_vxx (.clk, .en, .a(vx_r),   .b(vx_r),     .p(vxx_p), .sat(vxx_s));
  gas_mul u_vyy (.clk, .en, .a(vy_r),   .b(vy_r),     .p(vyy_p), .sat(vyy_s));
  gas_mul u_vzz (.clk, .en, .a(vz_r),   .b(vz_r),     .p(vzz_p), .sat(vzz_s));
  gas_mul u_v21 (.clk, .en, .a(vx_r),   .b(vr_r),     .p(v21_p), .sat(v21_s));
  gas_mul u_v31 (.clk, .en, .a(vy_r),   .b(vr_r),     .p(v31_p), .sat(v31_s));
  gas_mul u_v41 (.clk, .en, .a(vz_r),   .b(vr_r),     .p(v41_p), .sat(v41_s));

  gas_div u_inv (.clk, .en, .num(gas_pkg::FX_TWO), .den(r_r[0]), .q(inv_q), .sat(inv_s));

  gas_mul u_r3  (.clk, .en, .a(rr_p), .b(r_r[T_RR]), .p(r3_p), .sat(r3_s));
  gas_div u_z   (.clk, .en, .num(gas_pkg::FX_HALF), .den(rc_p), .q(z_q), .sat(z_s));
  gas_div u_gtt (.clk, .en, .num(a_r[T_R3].c), .den(r3_p), .q(gtt_q), .sat(gtt_s));

  always_comb begin
    s1 = gas_pkg::sat_add(vxx_p, vyy_p);
    s2 = gas_pkg::sat_add(s1.v, vzz_p);
    z2 = gas_pkg::sat_add(z_q, z_q);
    b_src = '{v01: v01_p, v11: v11_p, v00: v00_p, v21: v21_p, v31: v31_p,
              v41: v41_p, s: s2.v};
    f_rr = rr_s | rc_s | v01_s | v11_s | v00_s | vxx_s | vyy_s | vzz_s |
           v21_s | v31_s | v41_s | s1.sat | s2.sat;
    gth = gtt_q[DW-1] ? '0 : (gtt_q >>> 1);
  end

  gas_mul u_p0  (.clk, .en, .a(z_r[TA].z2), .b(b_r[TA].v01), .p(p0_p),  .sat(p0_s));
  gas_mul u_p1a (.clk, .en, .a(z_r[TA].z),  .b(b_r[TA].v11), .p(p1a_p), .sat(p1a_s));
  gas_mul u_p1b (.clk, .en, .a(a_r[TA].c),  .b(b_r[TA].s),   .p(p1b_p), .sat(p1b_s));
  gas_mul u_p1c (.clk, .en, .a(gth),        .b(b_r[TA].v00), .p(p1c_p), .sat(p1c_s));
  gas_mul u_p2x (.clk, .en, .a(inv_r[TA]),  .b(b_r[TA].v21), .p(p2x_p), .sat(p2x_s));
  gas_mul u_p2y (.clk, .en, .a(inv_r[TA]),  .b(b_r[TA].v31), .p(p2y_p), .sat(p2y_s));
  gas_mul u_p2z (.clk, .en, .a(inv_r[TA]),  .b(b_r[TA].v41), .p(p2z_p), .sat(p2z_s));
  gas_mul u_pdx (.clk, .en, .a(gas_pkg::dir_ext(a_r[TA].dx)), .b(b_r[TA].s),
                 .p(pdx_p), .sat(pdx_s));
  gas_mul u_pdy (.clk, .en, .a(gas_pkg::dir_ext(a_r[TA].dy)), .b(b_r[TA].s),
                 .p(pdy_p), .sat(pdy_s));
  gas_mul u_pdz (.clk, .en, .a(gas_pkg::dir_ext(a_r[TA].dz)), .b(b_r[TA].s),
                 .p(pdz_p), .sat(pdz_s));

  always_comb begin
    a0 = gas_pkg::sat_sub('0, p0_p);
    t1 = gas_pkg::sat_add(p1a_p, p1b_p);
    a1 = gas_pkg::sat_sub(t1.v, p1c_p);
    tx = gas_pkg::sat_add(p2x_p, pdx_p);
    ty = gas_pkg::sat_add(p2y_p, pdy_p);
    tz = gas_pkg::sat_add(p2z_p, pdz_p);
    ax = gas_pkg::sat_sub('0, tx.v);
    ay = gas_pkg::sat_sub('0, ty.v);
    az = gas_pkg::sat_sub('0, tz.v);
    f_p = p0_s | p1a_s | p1b_s | p1c_s | p2x_s | p2y_s | p2z_s | pdx_s | pdy_s |
          pdz_s | a0.sat | t1.sat | a1.sat | tx.sat | ty.sat | tz.sat |
          ax.sat | ay.sat | az.sat;
  end

  gas_mul u_f0 (.clk, .en, .a(acc_r[0]), .b(h_r[T_ACC]), .p(f0_p), .sat(f0_s));
  gas_mul u_f1 (.clk, .en, .a(acc_r[1]), .b(h_r[T_ACC]), .p(f1_p), .sat(f1_s));
  gas_mul u_f2 (.clk, .en, .a(acc_r[2]), .b(h_r[T_ACC]), .p(f2_p), .sat(f2_s));
  gas_mul u_f3 (.clk, .en, .a(acc_r[3]), .b(h_r[T_ACC]), .p(f3_p), .sat(f3_s));
  gas_mul u_f4 (.clk, .en, .a(acc_r[4]), .b(h_r[T_ACC]), .p(f4_p), .sat(f4_s));

  always_comb begin
    for (int k = 1; k <= T_OUT; k++) begin
      ctl_in[k] = ctl_r[k-1];
    end
    ctl_in[T_RR+1].flg  = ctl_r[T_RR].flg | f_rr;
    ctl_in[T_R3+1].flg  = ctl_r[T_R3].flg | r3_s;
    ctl_in[T_INV+1].flg = ctl_r[T_INV].flg | inv_s;
    ctl_in[T_Z+1].flg   = ctl_r[T_Z].flg | z_s | z2.sat;
    ctl_in[TA+1].flg    = ctl_r[TA].flg | gtt_s;
    ctl_in[T_P+1].flg   = ctl_r[T_P].flg | f_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= T_OUT; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= '{vld: in_valid, hz: in_pos_radius <= gas_pkg::FX_ONE, flg: 1'b0};
      for (int k = 1; k <= T_OUT; k++) begin
        ctl_r[k] <= ctl_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= '{c: in_pos_radius - gas_pkg::FX_ONE, dx: in_dir_x, dy: in_dir_y,
                  dz: in_dir_z};
      r_r[0] <= in_pos_radius;
      h_r[0] <= in_step_size;
      vt_r   <= in_vel_time;
      vr_r   <= in_vel_radius;
      vx_r   <= in_vel_x;
      vy_r   <= in_vel_y;
      vz_r   <= in_vel_z;
      for (int k = 1; k <= TA; k++) begin
        a_r[k] <= a_r[k-1];
      end
      for (int k = 1; k <= T_RR; k++) begin
        r_r[k] <= r_r[k-1];
      end
      for (int k = 1; k <= T_ACC; k++) begin
        h_r[k] <= h_r[k-1];
      end
      b_r[T_RR+1] <= b_src;
      for (int k = T_RR + 2; k <= TA; k++) begin
        b_r[k] <= b_r[k-1];
      end
      inv_r[T_INV+1] <= inv_q;
      for (int k = T_INV + 2; k <= TA; k++) begin
        inv_r[k] <= inv_r[k-1];
      end
      z_r[T_Z+1] <= '{z: z_q, z2: z2.v};
      for (int k = T_Z + 2; k <= TA; k++) begin
        z_r[k] <= z_r[k-1];
      end
      acc_r[0] <= a0.v;
      acc_r[1] <= a1.v;
      acc_r[2] <= ax.v;
      acc_r[3] <= ay.v;
      acc_r[4] <= az.v;
    end
  end

  always_comb begin
    f_out = f0_s | f1_s | f2_s | f3_s | f4_s;
    if (ctl_r[T_OUT].hz) begin
      pd = '{dt: '0, dr: '0, dx: '0, dy: '0, dz: '0, fault: 1'b1};
    end else begin
      pd = '{dt: f0_p, dr: f1_p, dx: f2_p, dy: f3_p, dz: f4_p,
             fault: ctl_r[T_OUT].flg | f_out};
    end
  end

  assign take = en && ctl_r[T_OUT].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : pd;
    end else if (take) begin
      skid_d_r <= pd;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dv_time   = out_d_r.dt;
  assign out_dv_radius = out_d_r.dr;
  assign out_dv_x      = out_d_r.dx;
  assign out_dv_y      = out_d_r.dy;
  assign out_dv_z      = out_d_r.dz;
  assign out_fault     = out_d_r.fault;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a result while the output is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without a blocked output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("result leaving the pipeline was lost");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (out_valid_r && !skid_v_r))
    else $error("skid did not drain into the output");

endmodule
